// File: design/rsd_pkg.sv
// rsd_pkg: shared types and constants of the rle sprite decoder
// used by rsd_front, rsd_queue, rsd_back and rle_sprite_decoder; no dependencies
package rsd_pkg;

    localparam int ADDR_W    = 21;
    localparam int WORD_W    = 16;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_W-1:0] MAX_ROWS = 11'd1024;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PITCH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FLIP_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FLIP_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OLD    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_NEW    = 3'd6;

    // command kinds passed from front to back
    localparam logic [1:0] CMD_PIX  = 2'd0;
    localparam logic [1:0] CMD_STEP = 2'd1;
    localparam logic [1:0] CMD_BASE = 2'd2;
    localparam logic [1:0] CMD_END  = 2'd3;

    typedef struct packed {
        logic [CFG_W-1:0] sprite_width;
        logic [CFG_W-1:0] sprite_height;
        logic [CFG_W-1:0] row_pitch;
        logic             flip_x;
        logic             flip_y;
        logic [7:0]       old_color;
        logic [7:0]       new_color;
    } cfg_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [ADDR_W-1:0] col;      // flipped column of a pixel
        logic [7:0]        pix;      // recolored pixel
        logic              adv;      // step row base after this pixel
        logic              set_base; // first group: load start row base
        logic [WORD_W-1:0] rows;     // whole rows to skip
    } cmd_t;

endpackage

// File: design/rsd_front.sv
// rsd_front: byte parser of the skip/copy stream, emits commands
// depends on rsd_pkg
module rsd_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  rsd_pkg::cfg_t       cfg,
    input  logic                in_valid,
    input  logic [7:0]          in_byte,
    output logic                in_ready,
    output logic                cmd_valid,
    output rsd_pkg::cmd_t       cmd,
    input  logic                cmd_ready
);

    localparam logic [3:0] PH_ROWS_LO   = 4'd0;
    localparam logic [3:0] PH_ROWS_HI   = 4'd1;
    localparam logic [3:0] PH_CHUNKS_LO = 4'd2;
    localparam logic [3:0] PH_CHUNKS_HI = 4'd3;
    localparam logic [3:0] PH_SKIP_LO   = 4'd4;
    localparam logic [3:0] PH_SKIP_HI   = 4'd5;
    localparam logic [3:0] PH_COPY_LO   = 4'd6;
    localparam logic [3:0] PH_COPY_HI   = 4'd7;
    localparam logic [3:0] PH_DATA      = 4'd8;

    logic [3:0]  phase_reg, phase_next;
    logic [7:0]  hold_reg, hold_next;
    logic [15:0] rows_reg, rows_next;
    logic [15:0] cpr_reg, cpr_next;
    logic [15:0] chunks_reg, chunks_next;
    logic [15:0] skip_reg, skip_next;
    logic [15:0] copy_reg, copy_next;
    logic        first_reg, first_next;

    logic        accept;
    logic [15:0] word;
    logic [15:0] ec_chunks, ec_rows;
    logic        ec_row_done;

    assign in_ready = cmd_ready;
    assign accept   = in_valid && cmd_ready;
    assign word     = {in_byte, hold_reg};

    // end of chunk bookkeeping
    always_comb begin
        ec_chunks   = (chunks_reg != 16'd0) ? chunks_reg - 16'd1 : 16'd0;
        ec_row_done = (ec_chunks == 16'd0);
        ec_rows     = (rows_reg != 16'd0) ? rows_reg - 16'd1 : 16'd0;
    end

    always_comb begin
        phase_next  = phase_reg;
        hold_next   = hold_reg;
        rows_next   = rows_reg;
        cpr_next    = cpr_reg;
        chunks_next = chunks_reg;
        skip_next   = skip_reg;
        copy_next   = copy_reg;
        first_next  = first_reg;
        cmd_valid   = 1'b0;
        cmd.kind     = rsd_pkg::CMD_PIX;
        cmd.col      = cfg.flip_x
            ? ({10'b0, cfg.sprite_width} - 21'd1 - {5'b0, skip_reg})
            : {5'b0, skip_reg};
        cmd.pix      = (cfg.old_color != cfg.new_color && in_byte == cfg.old_color)
            ? cfg.new_color : in_byte;
        cmd.adv      = 1'b0;
        cmd.set_base = first_reg;
        cmd.rows     = (word == 16'd0) ? rows_reg : 16'd0;

        if (accept) begin
            unique case (phase_reg)
                PH_ROWS_LO, PH_CHUNKS_LO, PH_SKIP_LO, PH_COPY_LO: begin
                    hold_next  = in_byte;
                    phase_next = phase_reg + 4'd1;
                end
                PH_ROWS_HI: begin
                    rows_next  = word;
                    phase_next = PH_CHUNKS_LO;
                end
                PH_CHUNKS_HI: begin
                    cmd_valid = 1'b1;
                    if (!first_reg && rows_reg == 16'd0) begin
                        cmd.kind    = rsd_pkg::CMD_END;
                        phase_next  = PH_ROWS_LO;
                        hold_next   = 8'd0;
                        rows_next   = 16'd0;
                        cpr_next    = 16'd0;
                        chunks_next = 16'd0;
                        skip_next   = 16'd0;
                        copy_next   = 16'd0;
                        first_next  = 1'b1;
                    end else begin
                        cmd.kind   = rsd_pkg::CMD_BASE;
                        first_next = 1'b0;
                        if (word == 16'd0) begin
                            rows_next  = 16'd0;
                            phase_next = PH_ROWS_LO;
                        end else if (rows_reg == 16'd0) begin
                            phase_next = PH_ROWS_LO;
                        end else begin
                            cpr_next    = word;
                            chunks_next = word;
                            phase_next  = PH_SKIP_LO;
                        end
                    end
                end
                PH_SKIP_HI: begin
                    skip_next  = word;
                    phase_next = PH_COPY_LO;
                end
                PH_COPY_HI, PH_DATA: begin
                    if (phase_reg == PH_DATA) begin
                        cmd_valid = 1'b1;
                        skip_next = skip_reg + 16'd1;
                        copy_next = copy_reg - 16'd1;
                    end else begin
                        copy_next = word;
                    end
                    if (copy_next == 16'd0) begin
                        chunks_next = ec_chunks;
                        phase_next  = PH_SKIP_LO;
                        if (ec_row_done) begin
                            // row finished: back steps its row base
                            cmd.adv   = 1'b1;
                            cmd.kind  = (phase_reg == PH_DATA) ? rsd_pkg::CMD_PIX
                                                               : rsd_pkg::CMD_STEP;
                            cmd_valid = 1'b1;
                            rows_next = ec_rows;
                            if (ec_rows != 16'd0) chunks_next = cpr_reg;
                            else phase_next = PH_ROWS_LO;
                        end
                    end else begin
                        phase_next = PH_DATA;
                    end
                end
                default: begin
                    phase_next  = PH_ROWS_LO;
                    hold_next   = 8'd0;
                    rows_next   = 16'd0;
                    cpr_next    = 16'd0;
                    chunks_next = 16'd0;
                    skip_next   = 16'd0;
                    copy_next   = 16'd0;
                    first_next  = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_ROWS_LO;
            hold_reg   <= 8'd0;
            rows_reg   <= 16'd0;
            cpr_reg    <= 16'd0;
            chunks_reg <= 16'd0;
            skip_reg   <= 16'd0;
            copy_reg   <= 16'd0;
            first_reg  <= 1'b1;
        end else begin
            phase_reg  <= phase_next;
            hold_reg   <= hold_next;
            rows_reg   <= rows_next;
            cpr_reg    <= cpr_next;
            chunks_reg <= chunks_next;
            skip_reg   <= skip_next;
            copy_reg   <= copy_next;
            first_reg  <= first_next;
        end
    end

endmodule

// File: design/rsd_queue.sv
// rsd_queue: two-entry command queue between front and back
// depends on rsd_pkg
module rsd_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push_valid,
    input  rsd_pkg::cmd_t push_cmd,
    output logic          push_ready,
    output logic          pop_valid,
    output rsd_pkg::cmd_t pop_cmd,
    input  logic          pop_ready
);

    rsd_pkg::cmd_t mem_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    count_reg;
    logic          do_push, do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_cmd    = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (do_push) mem_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (do_push) wr_ptr_reg <= ~wr_ptr_reg;
            if (do_pop)  rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

endmodule

// File: design/rsd_back.sv
// rsd_back: row base tracking, pixel address forming and output register
// depends on rsd_pkg
module rsd_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  rsd_pkg::cfg_t                 cfg,
    input  logic                          cmd_valid,
    input  rsd_pkg::cmd_t                 cmd,
    output logic                          cmd_ready,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [rsd_pkg::ADDR_W-1:0]    m_write_offset,
    output logic [7:0]                    m_pixel_value,
    output logic                          m_end_of_sprite
);

    logic [rsd_pkg::ADDR_W-1:0] base_reg;
    logic [rsd_pkg::ADDR_W-1:0] prod1_reg, prod2_reg;
    logic                       set_reg;
    logic                       pend_reg;
    logic                       valid_reg;
    logic [rsd_pkg::ADDR_W-1:0] offset_reg;
    logic [7:0]                 pixel_reg;
    logic                       eos_reg;

    logic [rsd_pkg::ADDR_W-1:0] step;
    logic [rsd_pkg::ADDR_W-1:0] h1;
    logic [rsd_pkg::CFG_W-1:0]  eff_h;
    logic [31:0]                mul1, mul2;
    logic                       out_free;
    logic                       pop;
    logic                       out_load;

    always_comb begin
        step  = cfg.flip_y ? (21'd0 - {10'b0, cfg.row_pitch}) : {10'b0, cfg.row_pitch};
        eff_h = (cfg.sprite_height > rsd_pkg::MAX_ROWS) ? rsd_pkg::MAX_ROWS
                                                        : cfg.sprite_height;
        h1    = {10'b0, eff_h} - 21'd1;
        mul1  = {11'b0, h1} * {21'b0, cfg.row_pitch};
        mul2  = {16'b0, cmd.rows} * {11'b0, step};
    end

    assign out_free  = !valid_reg || m_ready;
    assign cmd_ready = !pend_reg &&
                       (cmd.kind == rsd_pkg::CMD_BASE || cmd.kind == rsd_pkg::CMD_STEP ||
                        out_free);
    assign pop       = cmd_valid && cmd_ready;
    assign out_load  = pop && (cmd.kind == rsd_pkg::CMD_PIX || cmd.kind == rsd_pkg::CMD_END);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg  <= '0;
            pend_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= out_load || (valid_reg && !m_ready);
            if (pend_reg) begin
                base_reg <= (set_reg ? prod1_reg : base_reg) + prod2_reg;
                pend_reg <= 1'b0;
            end else if (pop) begin
                unique case (cmd.kind)
                    rsd_pkg::CMD_PIX: begin
                        if (cmd.adv) base_reg <= base_reg + step;
                    end
                    rsd_pkg::CMD_STEP: base_reg <= base_reg + step;
                    rsd_pkg::CMD_BASE: pend_reg <= 1'b1;
                    rsd_pkg::CMD_END:  base_reg <= '0;
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (!pend_reg && pop) begin
            if (cmd.kind == rsd_pkg::CMD_BASE) begin
                prod1_reg <= cfg.flip_y ? mul1[rsd_pkg::ADDR_W-1:0] : '0;
                prod2_reg <= mul2[rsd_pkg::ADDR_W-1:0];
                set_reg   <= cmd.set_base;
            end
            if (cmd.kind == rsd_pkg::CMD_PIX) begin
                offset_reg <= base_reg + cmd.col;
                pixel_reg  <= cmd.pix;
                eos_reg    <= 1'b0;
            end
            if (cmd.kind == rsd_pkg::CMD_END) begin
                offset_reg <= '0;
                pixel_reg  <= 8'd0;
                eos_reg    <= 1'b1;
            end
        end
    end

    assign m_valid         = valid_reg;
    assign m_write_offset  = offset_reg;
    assign m_pixel_value   = pixel_reg;
    assign m_end_of_sprite = eos_reg;

endmodule

// File: design/rle_sprite_decoder.sv
// rle_sprite_decoder: top level of the skip/copy rle sprite decoder
// depends on rsd_pkg, rsd_front, rsd_queue, rsd_back
//
// usage:
// - s_valid/s_ready/s_data_byte take one byte of the compressed stream per item
// - m_valid/m_ready carry one result item: a pixel write (offset, value) or an
//   end-of-sprite flag with zero offset and value; header bytes give no pixel write
// - cfg_wr_en/cfg_index/cfg_data write the seven registers, only while idle (the block itself does not enforce this)
// - throughput: one byte per cycle while m_ready stays high; the back end holds off
//   the queue after each group header for its registered row multiply, hidden by the header bytes
//   that follow, so a steady stream runs at one byte per cycle
// - a data byte's command is written into the queue, then into the output register, where its result shows
// - a stalled receiver holds the output register; the two-entry queue fills and
//   s_ready drops until the back end drains again
// - reset (synchronous, active low) restores register defaults and restarts the
//   parser at the first group of a new sprite with empty queue and output
module rle_sprite_decoder (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [rsd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rsd_pkg::CFG_W-1:0]         cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [7:0]                        s_data_byte,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [rsd_pkg::ADDR_W-1:0]        m_write_offset,
    output logic [7:0]                        m_pixel_value,
    output logic                              m_end_of_sprite
);

    rsd_pkg::cfg_t cfg_reg;

    // command path front -> queue -> back
    logic          f_valid, f_ready;
    rsd_pkg::cmd_t f_cmd;
    logic          b_valid, b_ready;
    rsd_pkg::cmd_t b_cmd;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sprite_width  <= 11'd1;
            cfg_reg.sprite_height <= 11'd1;
            cfg_reg.row_pitch     <= 11'd4;
            cfg_reg.flip_x        <= 1'b0;
            cfg_reg.flip_y        <= 1'b0;
            cfg_reg.old_color     <= 8'd0;
            cfg_reg.new_color     <= 8'd0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                rsd_pkg::REG_WIDTH:  cfg_reg.sprite_width  <= cfg_data;
                rsd_pkg::REG_HEIGHT: cfg_reg.sprite_height <= cfg_data;
                rsd_pkg::REG_PITCH:  cfg_reg.row_pitch     <= cfg_data;
                rsd_pkg::REG_FLIP_X: cfg_reg.flip_x        <= cfg_data[0];
                rsd_pkg::REG_FLIP_Y: cfg_reg.flip_y        <= cfg_data[0];
                rsd_pkg::REG_OLD:    cfg_reg.old_color     <= cfg_data[7:0];
                rsd_pkg::REG_NEW:    cfg_reg.new_color     <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // parser: header fields, chunk and row counts
    rsd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_valid),
        .in_byte   (s_data_byte),
        .in_ready  (s_ready),
        .cmd_valid (f_valid),
        .cmd       (f_cmd),
        .cmd_ready (f_ready)
    );

    // decouples the parser from output stalls
    rsd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (f_valid),
        .push_cmd   (f_cmd),
        .push_ready (f_ready),
        .pop_valid  (b_valid),
        .pop_cmd    (b_cmd),
        .pop_ready  (b_ready)
    );

    // row base and output register
    rsd_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg_reg),
        .cmd_valid       (b_valid),
        .cmd             (b_cmd),
        .cmd_ready       (b_ready),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_write_offset  (m_write_offset),
        .m_pixel_value   (m_pixel_value),
        .m_end_of_sprite (m_end_of_sprite)
    );

endmodule
